/* rtl/frame_rms_volume_top_assert.svh */
// assertion helpers, clk and rst_n must be visible where they are used
`ifndef FRAME_RMS_VOLUME_TOP_ASSERT_SVH
`define FRAME_RMS_VOLUME_TOP_ASSERT_SVH

// same-cycle implication
`define FRV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FRV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/frv_pkg.sv */
package frv_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int HOP_W      = 13;
    localparam int VOL_W      = 16;
    localparam int MAG_W      = 16;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = 43;
    localparam int DQ_W       = SUM_W + 1;
    localparam int ROOT_W     = DQ_W / 2;
    localparam int SREM_W     = ROOT_W + 3;
    localparam int DIV_STEPS  = DQ_W;
    localparam int SQRT_STEPS = DQ_W / 2;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int MAX_HOP    = 4096;
    localparam int HOP_RESET  = 512;
    localparam int FULL_SCALE = 32768;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_EMIT_FIRST,
        ST_DIV,
        ST_SQRT,
        ST_EMIT_FRAME
    } frv_state_t;

    typedef struct packed {
        logic load;
        logic square;
        logic accum;
        logic div_step;
        logic sqrt_step;
        logic sel_first;
    } frv_cmd_t;

    typedef struct packed {
        logic first;
        logic close_now;
        logic close;
        logic div_last;
        logic sqrt_last;
    } frv_stat_t;

endpackage

/* rtl/frv_in_if.sv */
interface frv_in_if;
    import frv_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clip_end;

    modport source (output valid, output sample, output clip_end, input ready);
    modport sink (input valid, input sample, input clip_end, output ready);
endinterface

/* rtl/frv_out_if.sv */
interface frv_out_if;
    import frv_pkg::*;

    logic             valid;
    logic             ready;
    logic [VOL_W-1:0] volume;
    logic             run_last;

    modport source (output valid, output volume, output run_last, input ready);
    modport sink (input valid, input volume, input run_last, output ready);
endinterface

/* rtl/frv_cfg_if.sv */
interface frv_cfg_if;
    import frv_pkg::*;

    logic             valid;
    logic             ready;
    logic [HOP_W-1:0] hop_size;

    modport source (output valid, output hop_size, input ready);
    modport sink (input valid, input hop_size, output ready);
endinterface

/* rtl/frv_ctrl.sv */
module frv_ctrl
    import frv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output logic      run_last,
    output frv_cmd_t  cmd,
    input  frv_stat_t stat
);

    frv_state_t state_reg;
    frv_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        run_last   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum = 1'b1;
                priority if (stat.first)
                begin
                    state_next = ST_EMIT_FIRST;
                end
                else if (stat.close_now)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_FIRST:
            begin
                out_valid     = 1'b1;
                cmd.sel_first = 1'b1;
                run_last      = !stat.close;
                if (out_ready)
                begin
                    state_next = stat.close ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_last)
                begin
                    state_next = ST_EMIT_FRAME;
                end
            end
            ST_EMIT_FRAME:
            begin
                out_valid = 1'b1;
                run_last  = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `include "frame_rms_volume_top_assert.svh"

    `FRV_ASSERT_NOW(a_one_side, in_ready, !out_valid, "input and output open together")
    `FRV_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready && !out_valid,
        "block not busy after item accepted")
    `FRV_ASSERT_NEXT(a_idle_after_last, out_valid && out_ready && run_last, in_ready,
        "block not idle after last result")
    `FRV_ASSERT_NEXT(a_div_to_sqrt, state_reg == ST_DIV && stat.div_last,
        state_reg == ST_SQRT, "root did not follow divide")

endmodule

/* rtl/frv_dp.sv */
module frv_dp
    import frv_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       clip_end,
    input  logic                       cfg_valid,
    input  logic [HOP_W-1:0]           cfg_hop,
    output logic [VOL_W-1:0]           volume,
    input  frv_cmd_t                   cmd,
    output frv_stat_t                  stat
);

    // control state
    logic [HOP_W-1:0]  hop_reg, hop_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [HOP_W-1:0]  count_reg, count_next;
    logic              pending_reg, pending_next;
    logic              first_reg, first_next;
    logic              last_reg, last_next;
    logic              close_reg, close_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // payload
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [HOP_W-1:0]  div_reg, div_next;
    logic [DQ_W-1:0]   dq_reg, dq_next;
    logic [HOP_W-1:0]  rem_reg, rem_next;
    logic [SREM_W-1:0] srem_reg, srem_next;
    logic [ROOT_W-1:0] root_reg, root_next;

    logic [SAMPLE_W:0] sample_ext;
    logic [SAMPLE_W:0] mag_full;
    logic [HOP_W-1:0]  hop_eff;
    logic [SUM_W-1:0]  acc;
    logic [HOP_W-1:0]  count_inc;
    logic              close_now;
    logic [HOP_W:0]    div_shift;
    logic              div_bit;
    logic [SREM_W-1:0] sq_shift;
    logic [SREM_W-1:0] sq_trial;
    logic              sq_bit;
    logic              div_last;
    logic              sqrt_last;

    always_comb
    begin
        sample_ext = {sample[SAMPLE_W-1], sample};
        mag_full   = sample[SAMPLE_W-1] ? (~sample_ext + 1'b1) : sample_ext;

        priority if (hop_reg == '0)
        begin
            hop_eff = HOP_W'(1);
        end
        else if (hop_reg > HOP_W'(MAX_HOP))
        begin
            hop_eff = HOP_W'(MAX_HOP);
        end
        else
        begin
            hop_eff = hop_reg;
        end

        acc       = sum_reg + SUM_W'(sq_reg);
        count_inc = count_reg + 1'b1;
        close_now = count_inc >= hop_eff;

        // restoring divide, one quotient bit per step
        div_shift = {rem_reg, dq_reg[DQ_W-1]};
        div_bit   = div_shift >= {1'b0, div_reg};

        // digit-by-digit root, two radicand bits per step
        sq_shift  = {srem_reg[SREM_W-3:0], dq_reg[DQ_W-1 -: 2]};
        sq_trial  = {1'b0, root_reg, 2'b01};
        sq_bit    = sq_shift >= sq_trial;

        div_last  = step_reg == STEP_W'(DIV_STEPS - 1);
        sqrt_last = step_reg == STEP_W'(SQRT_STEPS - 1);

        hop_next     = cfg_valid ? cfg_hop : hop_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        pending_next = pending_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        close_next   = close_reg;
        step_next    = step_reg;
        mag_next     = mag_reg;
        sq_next      = sq_reg;
        div_next     = div_reg;
        dq_next      = dq_reg;
        rem_next     = rem_reg;
        srem_next    = srem_reg;
        root_next    = root_reg;

        if (cmd.load)
        begin
            mag_next     = mag_full[MAG_W-1:0];
            last_next    = clip_end;
            first_next   = pending_reg;
            pending_next = 1'b0;
        end

        if (cmd.square)
        begin
            sq_next = mag_reg * mag_reg;
        end

        if (cmd.accum)
        begin
            close_next = close_now;
            if (close_now)
            begin
                sum_next   = '0;
                count_next = '0;
                dq_next    = {1'b0, acc};
                div_next   = hop_eff;
                rem_next   = '0;
                step_next  = '0;
            end
            else
            begin
                sum_next   = acc;
                count_next = count_inc;
            end
            if (last_reg)
            begin
                sum_next     = '0;
                count_next   = '0;
                pending_next = 1'b1;
            end
        end

        if (cmd.div_step)
        begin
            rem_next = div_bit ? HOP_W'(div_shift - {1'b0, div_reg}) : div_shift[HOP_W-1:0];
            dq_next  = {dq_reg[DQ_W-2:0], div_bit};
            if (div_last)
            begin
                step_next = '0;
                srem_next = '0;
                root_next = '0;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end

        if (cmd.sqrt_step)
        begin
            srem_next = sq_bit ? (sq_shift - sq_trial) : sq_shift;
            root_next = {root_reg[ROOT_W-2:0], sq_bit};
            dq_next   = {dq_reg[DQ_W-3:0], 2'b00};
            step_next = sqrt_last ? '0 : step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_reg     <= HOP_W'(HOP_RESET);
            sum_reg     <= '0;
            count_reg   <= '0;
            pending_reg <= 1'b1;
            first_reg   <= 1'b0;
            last_reg    <= 1'b0;
            close_reg   <= 1'b0;
            step_reg    <= '0;
        end
        else
        begin
            hop_reg     <= hop_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
            first_reg   <= first_next;
            last_reg    <= last_next;
            close_reg   <= close_next;
            step_reg    <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        sq_reg   <= sq_next;
        div_reg  <= div_next;
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
    end

    always_comb
    begin
        if (cmd.sel_first)
        begin
            volume = mag_reg;
        end
        else if (root_reg > ROOT_W'(FULL_SCALE))
        begin
            volume = VOL_W'(FULL_SCALE);
        end
        else
        begin
            volume = root_reg[VOL_W-1:0];
        end
    end

    assign stat.first     = first_reg;
    assign stat.close_now = close_now;
    assign stat.close     = close_reg;
    assign stat.div_last  = div_last;
    assign stat.sqrt_last = sqrt_last;

endmodule

/* rtl/frame_rms_volume_top.sv */
// order: frame zero leaves once its item is squared and accumulated; a closed frame
// leaves after the item that closes it runs a 44-step divider, then a 22-step root
// flow: one item at a time; the next item waits until the last is squared and
// accumulated, its results taken and any iterative divide and root run is done
// reset: rst_n clears the open frame, sets hop_size to 512, block idle at once
module frame_rms_volume_top
    import frv_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    frv_in_if.sink     pcm,
    frv_out_if.source  vol,
    frv_cfg_if.sink    cfg
);

    frv_cmd_t  cmd;
    frv_stat_t stat;
    logic      in_ready;
    logic      out_valid;
    logic      run_last;

    frv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pcm.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (vol.ready),
        .run_last  (run_last),
        .cmd       (cmd),
        .stat      (stat)
    );

    frv_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (pcm.sample),
        .clip_end  (pcm.clip_end),
        .cfg_valid (cfg.valid),
        .cfg_hop   (cfg.hop_size),
        .volume    (vol.volume),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign pcm.ready    = in_ready;
    assign vol.valid    = out_valid;
    assign vol.run_last = run_last;
    assign cfg.ready    = 1'b1;

endmodule
